[hdl/set_assoc_cache_tag_lookup_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag lookup block
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SATL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
`define SATL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SATL_ASSERT_SAME(lbl, ck, rn, ante, cons, msg)
`define SATL_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[hdl/satl_pkg.sv]
// ----------------------------------------------------------------------------
// satl_pkg
// Shared constants, codes and types of the cache tag lookup block.
// ----------------------------------------------------------------------------
package satl_pkg;

    localparam int TOTAL_LINES = 64;
    localparam int LINE_BYTES  = 64;

    localparam int LINE_W     = $clog2(TOTAL_LINES);
    localparam int OFF_W      = $clog2(LINE_BYTES);
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = ADDR_W - OFF_W;
    localparam int WAYLOG_W   = $clog2(LINE_W + 1);
    localparam int TIME_W     = 32;
    localparam int CNT_W      = 32;
    localparam int TOT_W      = 64;
    localparam int WAY_OUT_W  = 6;
    localparam int POL_W      = 2;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_MODE     = 2'd1;

    localparam logic [POL_W-1:0] POL_LRU = 2'd0;
    localparam logic [POL_W-1:0] POL_LFU = 2'd1;
    localparam logic [POL_W-1:0] POL_RR  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_DIRECT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_2WAY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_4WAY   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_8WAY   = 3'd3;

    // classified access, as handed from front to back
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] set_idx;
        logic [LINE_W-1:0] base;
        logic [LINE_W-1:0] way_last;
        logic [TIME_W-1:0] now;
    } item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] last_use;
        logic [CNT_W-1:0]  use_count;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic load;
    } back_stat_t;

endpackage

[hdl/satl_req_if.sv]
// ----------------------------------------------------------------------------
// satl_req_if
// Access request channel: byte address and time stamp.
// ----------------------------------------------------------------------------
interface satl_req_if import satl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] byte_address;
    logic [TIME_W-1:0] access_time;

    modport source (output valid, output byte_address, output access_time, input ready);
    modport sink   (input valid, input byte_address, input access_time, output ready);
endinterface

[hdl/satl_rsp_if.sv]
// ----------------------------------------------------------------------------
// satl_rsp_if
// Lookup result channel.
// ----------------------------------------------------------------------------
interface satl_rsp_if import satl_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    logic                 evicted;
    logic [TOT_W-1:0]     hit_total;
    logic [TOT_W-1:0]     miss_total;

    modport source (output valid, output hit, output way_used, output evicted,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input evicted,
                    input hit_total, input miss_total, output ready);
endinterface

[hdl/satl_cfg_if.sv]
// ----------------------------------------------------------------------------
// satl_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
interface satl_cfg_if import satl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/set_assoc_cache_tag_lookup.sv]
// Path from request transaction to result valid: queue and pop, one tag read per
// way plus one compare, write-back.
// The back handles one access at a time, the tag memory being scanned one way
// per cycle; ways is 1, 2, 4, 8 or 64.
// Reset (rst_n, asynchronous, active low): all lines invalid, round-robin
// pointers zero, totals zero, policy round robin, direct mapped. No clearing pass.
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag store of a set-associative cache with LRU, LFU or round-robin refill.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_lookup_assert.svh"

module set_assoc_cache_tag_lookup import satl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    satl_req_if.sink   req,
    satl_rsp_if.source rsp,
    satl_cfg_if.sink   cfg
);

    // front -> queue -> back
    logic             q_push;
    logic             q_pop;
    item_t            q_in_item;
    item_t            q_out_item;
    q_stat_t          q_stat;
    back_stat_t       b_stat;
    logic [POL_W-1:0] policy;

    // front: config registers, address split into set index, line base and tag
    satl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .q_stat    (q_stat),
        .push      (q_push),
        .push_item (q_in_item),
        .policy    (policy)
    );

    // short queue so the front keeps taking transactions while a set is scanned
    satl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in_item),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .q_stat    (q_stat)
    );

    // back: way scan, victim choice, line write-back and the result register
    satl_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_item (q_out_item),
        .pop    (q_pop),
        .policy (policy),
        .rsp    (rsp),
        .b_stat (b_stat)
    );

    `SATL_ASSERT_SAME(a_hit_no_evict, clk, rst_n, rsp.valid && rsp.hit, !rsp.evicted, "evicted on a hit")
    `SATL_ASSERT_SAME(a_no_push_full, clk, rst_n, q_push, !q_stat.full, "push into full queue")
    `SATL_ASSERT_SAME(a_load_free, clk, rst_n, b_stat.load, !rsp.valid || rsp.ready, "result overwritten")
    `SATL_ASSERT_NEXT(a_pop_busy, clk, rst_n, q_pop, b_stat.busy, "back idle after pop")

endmodule

[hdl/satl_front.sv]
// ----------------------------------------------------------------------------
// satl_front
// Holds the configuration and splits each address into set and tag.
// ----------------------------------------------------------------------------
module satl_front import satl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    satl_req_if.sink         req,
    satl_cfg_if.sink         cfg,
    input  q_stat_t          q_stat,
    output logic             push,
    output item_t            push_item,
    output logic [POL_W-1:0] policy
);

    logic [POL_W-1:0]    policy_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [WAYLOG_W-1:0] ways_log2;
    logic [WAYLOG_W-1:0] idx_bits;
    logic [6:0]          shamt;
    logic [LINE_W-1:0]   set_mask;
    logic [LINE_W-1:0]   set_idx;
    logic [ADDR_W-1:0]   tag_full;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_RR;
            mode_reg   <= MODE_DIRECT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_REPLACE_POLICY: policy_reg <= cfg.data[POL_W-1:0];
                CFG_ASSOC_MODE:     mode_reg   <= cfg.data;
                default:            ;
            endcase
        end
    end

    // unknown modes act as fully associative
    always_comb
    begin
        case (mode_reg)
            MODE_DIRECT: ways_log2 = WAYLOG_W'(0);
            MODE_2WAY:   ways_log2 = WAYLOG_W'(1);
            MODE_4WAY:   ways_log2 = WAYLOG_W'(2);
            MODE_8WAY:   ways_log2 = WAYLOG_W'(3);
            default:     ways_log2 = WAYLOG_W'(LINE_W);
        endcase
    end

    assign idx_bits = WAYLOG_W'(LINE_W) - ways_log2;
    assign shamt    = 7'(OFF_W) + 7'(idx_bits);
    assign set_mask = ~({LINE_W{1'b1}} << idx_bits);
    assign set_idx  = LINE_W'(req.byte_address >> OFF_W) & set_mask;
    assign tag_full = req.byte_address >> shamt;

    assign push_item.tag      = tag_full[TAG_W-1:0];
    assign push_item.set_idx  = set_idx;
    assign push_item.base     = set_idx << ways_log2;
    assign push_item.way_last = ~({LINE_W{1'b1}} << ways_log2);
    assign push_item.now      = req.access_time;

    assign req.ready = !q_stat.full;
    assign push      = req.valid && !q_stat.full;
    assign policy    = policy_reg;

endmodule

[hdl/satl_queue.sv]
// ----------------------------------------------------------------------------
// satl_queue
// Two-entry queue of classified accesses between front and back.
// ----------------------------------------------------------------------------
module satl_queue import satl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t q_stat
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    assign pop_item     = slot_reg[rd_ptr_reg];
    assign q_stat.full  = count_reg == 2'd2;
    assign q_stat.empty = count_reg == 2'd0;

endmodule

[hdl/satl_back.sv]
// ----------------------------------------------------------------------------
// satl_back
// Scans one set a way per cycle, picks the line and writes it back.
// ----------------------------------------------------------------------------
module satl_back import satl_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  q_stat_t          q_stat,
    input  item_t            q_item,
    output logic             pop,
    input  logic [POL_W-1:0] policy,
    satl_rsp_if.source       rsp,
    output back_stat_t       b_stat
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE} state_t;

    entry_t            line_mem [TOTAL_LINES];
    logic [LINE_W-1:0] rr_mem   [TOTAL_LINES];
    logic              line_valid_reg [TOTAL_LINES];
    logic              rr_valid_reg   [TOTAL_LINES];
    entry_t            rd_entry_reg;
    logic [LINE_W-1:0] rr_rd_reg;

    state_t            state_reg, state_next;
    item_t             cur_reg, cur_next;
    logic [LINE_W-1:0] iss_reg, iss_next;
    logic              iss_done_reg, iss_done_next;
    logic              ev_vld_reg, ev_vld_next;
    logic [LINE_W-1:0] ev_way_reg, ev_way_next;
    logic              hit_reg, hit_next;
    logic [LINE_W-1:0] hit_way_reg, hit_way_next;
    logic [CNT_W-1:0]  hit_cnt_reg, hit_cnt_next;
    logic              inv_reg, inv_next;
    logic [LINE_W-1:0] inv_way_reg, inv_way_next;
    logic [TIME_W-1:0] min_last_reg, min_last_next;
    logic [LINE_W-1:0] lru_way_reg, lru_way_next;
    logic [CNT_W-1:0]  min_cnt_reg, min_cnt_next;
    logic [LINE_W-1:0] lfu_way_reg, lfu_way_next;
    logic [TOT_W-1:0]  hit_tot_reg, hit_tot_next;
    logic [TOT_W-1:0]  miss_tot_reg, miss_tot_next;
    logic              out_vld_reg, out_vld_next;
    logic              out_hit_reg, out_hit_next;
    logic [WAY_OUT_W-1:0] out_way_reg, out_way_next;
    logic              out_evict_reg, out_evict_next;

    logic              can_load;
    logic              do_write;
    logic [LINE_W-1:0] rd_line;
    logic [LINE_W-1:0] ev_line;
    logic              ev_valid;
    logic [LINE_W-1:0] rr_val;
    logic [LINE_W-1:0] victim;
    logic [LINE_W-1:0] wr_line;
    entry_t            wr_entry;
    logic              evict;

    assign can_load = !out_vld_reg || rsp.ready;
    assign do_write = (state_reg == ST_WRITE) && can_load;
    assign pop      = (state_reg == ST_IDLE) && !q_stat.empty;
    assign rd_line  = cur_reg.base + iss_reg;
    assign ev_line  = cur_reg.base + ev_way_reg;
    assign ev_valid = line_valid_reg[ev_line];
    assign rr_val   = rr_valid_reg[cur_reg.set_idx] ? rr_rd_reg : '0;
    assign evict    = !hit_reg && !inv_reg;

    always_comb
    begin
        if (hit_reg)
            victim = hit_way_reg;
        else if (inv_reg)
            victim = inv_way_reg;
        else if (policy == POL_LRU)
            victim = lru_way_reg;
        else if (policy == POL_LFU)
            victim = lfu_way_reg;
        else
            victim = rr_val & cur_reg.way_last;
    end

    assign wr_line           = cur_reg.base + victim;
    assign wr_entry.tag      = cur_reg.tag;
    assign wr_entry.last_use = cur_reg.now;
    assign wr_entry.use_count = !hit_reg ? CNT_W'(1) :
                                (&hit_cnt_reg) ? hit_cnt_reg : hit_cnt_reg + CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (do_write)
            line_mem[wr_line] <= wr_entry;
        rd_entry_reg <= line_mem[rd_line];
    end

    always_ff @(posedge clk)
    begin
        if (do_write && evict && policy != POL_LRU && policy != POL_LFU)
            rr_mem[cur_reg.set_idx] <= (victim + LINE_W'(1)) & cur_reg.way_last;
        rr_rd_reg <= rr_mem[cur_reg.set_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LINES; i++)
            begin
                line_valid_reg[i] <= 1'b0;
                rr_valid_reg[i]   <= 1'b0;
            end
        end
        else if (do_write)
        begin
            line_valid_reg[wr_line] <= 1'b1;
            if (evict && policy != POL_LRU && policy != POL_LFU)
                rr_valid_reg[cur_reg.set_idx] <= 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        iss_next       = iss_reg;
        iss_done_next  = iss_done_reg;
        ev_vld_next    = 1'b0;
        ev_way_next    = ev_way_reg;
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        hit_cnt_next   = hit_cnt_reg;
        inv_next       = inv_reg;
        inv_way_next   = inv_way_reg;
        min_last_next  = min_last_reg;
        lru_way_next   = lru_way_reg;
        min_cnt_next   = min_cnt_reg;
        lfu_way_next   = lfu_way_reg;
        hit_tot_next   = hit_tot_reg;
        miss_tot_next  = miss_tot_reg;
        out_vld_next   = out_vld_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_way_next   = out_way_reg;
        out_evict_next = out_evict_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    cur_next      = q_item;
                    iss_next      = '0;
                    iss_done_next = 1'b0;
                    hit_next      = 1'b0;
                    inv_next      = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read of way iss_reg issued this cycle
                if (!iss_done_reg)
                begin
                    ev_vld_next = 1'b1;
                    ev_way_next = iss_reg;
                    iss_next    = iss_reg + LINE_W'(1);
                    if (iss_reg == cur_reg.way_last)
                        iss_done_next = 1'b1;
                end
                // way ev_way_reg compared this cycle
                if (ev_vld_reg)
                begin
                    if (ev_valid && rd_entry_reg.tag == cur_reg.tag && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_way_next = ev_way_reg;
                        hit_cnt_next = rd_entry_reg.use_count;
                    end
                    if (!ev_valid && !inv_reg)
                    begin
                        inv_next     = 1'b1;
                        inv_way_next = ev_way_reg;
                    end
                    if (ev_way_reg == '0 || rd_entry_reg.last_use < min_last_reg)
                    begin
                        min_last_next = rd_entry_reg.last_use;
                        lru_way_next  = ev_way_reg;
                    end
                    if (ev_way_reg == '0 || rd_entry_reg.use_count < min_cnt_reg)
                    begin
                        min_cnt_next = rd_entry_reg.use_count;
                        lfu_way_next = ev_way_reg;
                    end
                    if (ev_way_reg == cur_reg.way_last)
                        state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (can_load)
                begin
                    if (hit_reg)
                        hit_tot_next = hit_tot_reg + TOT_W'(1);
                    else
                        miss_tot_next = miss_tot_reg + TOT_W'(1);
                    out_vld_next   = 1'b1;
                    out_hit_next   = hit_reg;
                    out_way_next   = WAY_OUT_W'(victim);
                    out_evict_next = evict;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            iss_reg       <= '0;
            iss_done_reg  <= 1'b0;
            ev_vld_reg    <= 1'b0;
            ev_way_reg    <= '0;
            hit_reg       <= 1'b0;
            hit_way_reg   <= '0;
            hit_cnt_reg   <= '0;
            inv_reg       <= 1'b0;
            inv_way_reg   <= '0;
            min_last_reg  <= '0;
            lru_way_reg   <= '0;
            min_cnt_reg   <= '0;
            lfu_way_reg   <= '0;
            hit_tot_reg   <= '0;
            miss_tot_reg  <= '0;
            out_vld_reg   <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_way_reg   <= '0;
            out_evict_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            iss_reg       <= iss_next;
            iss_done_reg  <= iss_done_next;
            ev_vld_reg    <= ev_vld_next;
            ev_way_reg    <= ev_way_next;
            hit_reg       <= hit_next;
            hit_way_reg   <= hit_way_next;
            hit_cnt_reg   <= hit_cnt_next;
            inv_reg       <= inv_next;
            inv_way_reg   <= inv_way_next;
            min_last_reg  <= min_last_next;
            lru_way_reg   <= lru_way_next;
            min_cnt_reg   <= min_cnt_next;
            lfu_way_reg   <= lfu_way_next;
            hit_tot_reg   <= hit_tot_next;
            miss_tot_reg  <= miss_tot_next;
            out_vld_reg   <= out_vld_next;
            out_hit_reg   <= out_hit_next;
            out_way_reg   <= out_way_next;
            out_evict_reg <= out_evict_next;
        end
    end

    assign rsp.valid      = out_vld_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.way_used   = out_way_reg;
    assign rsp.evicted    = out_evict_reg;
    assign rsp.hit_total  = hit_tot_reg;
    assign rsp.miss_total = miss_tot_reg;

    assign b_stat.busy = state_reg != ST_IDLE;
    assign b_stat.load = do_write;

endmodule
